// ===== rtl/core/gfq_pkg.sv =====
// ----------------------------------------------------------------------------
// gfq_pkg
// Shared types and codes of the grouped FIFO queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package gfq_pkg;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DEQUEUED = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ENQ,
        S_DEQ_RING,
        S_DEQ_GROUP,
        S_DEQ_ENTRY
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/core/gfq_ram.sv =====
// ----------------------------------------------------------------------------
// gfq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gfq_ram #(
    parameter int W  = 8,
    parameter int D  = 16,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/grouped_fifo_queue.sv =====
// ----------------------------------------------------------------------------
// grouped_fifo_queue
// Two-level FIFO: members queue within groups, groups queue in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low. i_cmd selects
//   enqueue (group and member) or dequeue of the head member.
//   Exactly one result per transaction: o_valid pulses for one cycle with
//   o_status, o_out_group and o_out_member (group/member zero unless dequeued).
//   Enqueue passes through S_ENQ; dequeue reads ring, group and entry in turn
//   from the synchronous RAMs, then writes back. Rejected transactions (full,
//   bad group, empty) are answered from idle. The result appears the cycle
//   after the last working cycle, and a new transaction may be taken in that
//   cycle. After reset busy stays high while the group table is swept clear,
//   one entry per cycle. The receiver cannot stall: results are presented
//   once and are not held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module grouped_fifo_queue
    import gfq_pkg::*;
#(
    parameter int GROUPS  = 1024,
    parameter int ENTRIES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cmd,
    input  wire logic [9:0]  i_group_id,
    input  wire logic [9:0]  i_member_id,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [9:0]       o_out_group,
    output logic [9:0]       o_out_member
);

    localparam int EW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int GW = $clog2(GROUPS);
    localparam int OW = $clog2(GROUPS + 1);
    localparam int TW = 1 + 2 * EW;

    t_state r_state, n_state;

    logic [GW-1:0] r_clr;
    logic [CW-1:0] r_free, r_min;
    logic [GW-1:0] r_ohead, r_otail;
    logic [OW-1:0] r_ocount;
    logic [GW-1:0] r_grp;
    logic [9:0]    r_member;
    logic [EW-1:0] r_head, r_tail;

    logic          fs_we;
    logic [EW-1:0] fs_waddr, fs_wdata, fs_raddr, fs_rdata;
    logic          gt_we;
    logic [GW-1:0] gt_waddr, gt_raddr;
    logic [TW-1:0] gt_wdata, gt_rdata;
    logic          or_we;
    logic [GW-1:0] or_rdata;
    logic          em_we;
    logic [EW-1:0] em_waddr, e_raddr;
    logic [9:0]    em_rdata;
    logic          en_we;
    logic [EW-1:0] en_waddr, en_rdata;

    logic          g_active;
    logic [EW-1:0] g_head, g_tail, e_new, pop_pos;
    logic [CW-1:0] pop_cnt;
    logic          bad_grp, accept;

    assign g_active = gt_rdata[TW-1];
    assign g_head   = gt_rdata[2*EW-1:EW];
    assign g_tail   = gt_rdata[EW-1:0];
    assign pop_cnt  = r_free - CW'(1);
    assign pop_pos  = pop_cnt[EW-1:0];
    assign e_new    = (pop_cnt < r_min) ? pop_pos : fs_rdata;
    assign bad_grp  = (32'(i_group_id) >= GROUPS);
    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;

    function automatic logic [GW-1:0] ring_next(input logic [GW-1:0] pos);
        return (32'(pos) + 1 >= GROUPS) ? '0 : GW'(32'(pos) + 1);
    endfunction

    gfq_ram #(.W(EW), .D(ENTRIES), .AW(EW)) u_free (
        .i_clk(i_clk), .i_we(fs_we), .i_waddr(fs_waddr), .i_wdata(fs_wdata),
        .i_raddr(fs_raddr), .o_rdata(fs_rdata)
    );
    gfq_ram #(.W(TW), .D(GROUPS), .AW(GW)) u_group (
        .i_clk(i_clk), .i_we(gt_we), .i_waddr(gt_waddr), .i_wdata(gt_wdata),
        .i_raddr(gt_raddr), .o_rdata(gt_rdata)
    );
    gfq_ram #(.W(GW), .D(GROUPS), .AW(GW)) u_order (
        .i_clk(i_clk), .i_we(or_we), .i_waddr(r_otail), .i_wdata(r_grp),
        .i_raddr(r_ohead), .o_rdata(or_rdata)
    );
    gfq_ram #(.W(10), .D(ENTRIES), .AW(EW)) u_member (
        .i_clk(i_clk), .i_we(em_we), .i_waddr(em_waddr), .i_wdata(r_member),
        .i_raddr(e_raddr), .o_rdata(em_rdata)
    );
    gfq_ram #(.W(EW), .D(ENTRIES), .AW(EW)) u_next (
        .i_clk(i_clk), .i_we(en_we), .i_waddr(en_waddr), .i_wdata(e_new),
        .i_raddr(e_raddr), .o_rdata(en_rdata)
    );

    always_comb begin
        n_state  = r_state;
        fs_we    = 1'b0;
        fs_waddr = r_free[EW-1:0];
        fs_wdata = r_head;
        fs_raddr = pop_pos;
        gt_we    = 1'b0;
        gt_waddr = r_grp;
        gt_wdata = '0;
        gt_raddr = GW'(i_group_id);
        or_we    = 1'b0;
        em_we    = 1'b0;
        em_waddr = e_new;
        en_we    = 1'b0;
        en_waddr = g_tail;
        e_raddr  = g_head;
        unique case (r_state)
            S_CLEAR: begin
                gt_we    = 1'b1;
                gt_waddr = r_clr;
                if (32'(r_clr) == GROUPS - 1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_ENQ) begin
                        if (!bad_grp && r_free != '0) n_state = S_ENQ;
                    end else if (r_ocount != '0) begin
                        n_state = S_DEQ_RING;
                    end
                end
            end
            S_ENQ: begin
                em_we    = 1'b1;
                en_we    = g_active;
                gt_we    = 1'b1;
                gt_wdata = g_active ? {1'b1, g_head, e_new} : {1'b1, e_new, e_new};
                or_we    = !g_active;
                n_state  = S_IDLE;
            end
            S_DEQ_RING: begin
                gt_raddr = or_rdata;
                n_state  = S_DEQ_GROUP;
            end
            S_DEQ_GROUP: begin
                n_state = S_DEQ_ENTRY;
            end
            S_DEQ_ENTRY: begin
                gt_we    = 1'b1;
                gt_wdata = (r_head == r_tail) ? '0 : {1'b1, en_rdata, r_tail};
                fs_we    = (r_free < CW'(ENTRIES));
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_free   <= CW'(ENTRIES);
            r_min    <= CW'(ENTRIES);
            r_ohead  <= '0;
            r_otail  <= '0;
            r_ocount <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + GW'(1);
                S_IDLE: begin
                    if (accept) begin
                        r_grp        <= GW'(i_group_id);
                        r_member     <= i_member_id;
                        o_out_group  <= '0;
                        o_out_member <= '0;
                        if (i_cmd == CMD_ENQ) begin
                            if (bad_grp || r_free == '0) begin
                                o_valid  <= 1'b1;
                                o_status <= ST_FULL;
                            end
                        end else if (r_ocount == '0) begin
                            o_valid  <= 1'b1;
                            o_status <= ST_EMPTY;
                        end
                    end
                end
                S_ENQ: begin
                    r_free <= pop_cnt;
                    if (pop_cnt < r_min) r_min <= pop_cnt;
                    if (!g_active) begin
                        r_otail  <= ring_next(r_otail);
                        r_ocount <= r_ocount + OW'(1);
                    end
                    o_valid  <= 1'b1;
                    o_status <= ST_ENQUEUED;
                end
                S_DEQ_RING: r_grp <= or_rdata;
                S_DEQ_GROUP: begin
                    r_head <= g_head;
                    r_tail <= g_tail;
                end
                S_DEQ_ENTRY: begin
                    if (r_head == r_tail) begin
                        r_ohead  <= ring_next(r_ohead);
                        r_ocount <= r_ocount - OW'(1);
                    end
                    if (r_free < CW'(ENTRIES)) r_free <= r_free + CW'(1);
                    o_valid      <= 1'b1;
                    o_status     <= ST_DEQUEUED;
                    o_out_group  <= 10'(r_grp);
                    o_out_member <= em_rdata;
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for grouped_fifo_queue: directed and random enqueue /
// dequeue transactions, predicted by a local two-level FIFO model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
    import gfq_pkg::*;

    localparam int GROUPS  = 1024;
    localparam int ENTRIES = 4096;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] grp;
        logic [9:0] mem;
    } t_outcome;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic       i_cmd;
    logic [9:0] i_group_id;
    logic [9:0] i_member_id;
    logic       o_valid;
    logic [1:0] o_status;
    logic [9:0] o_out_group;
    logic [9:0] o_out_member;

    grouped_fifo_queue #(.GROUPS(GROUPS), .ENTRIES(ENTRIES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_group_id(i_group_id), .i_member_id(i_member_id),
        .o_valid(o_valid), .o_status(o_status), .o_out_group(o_out_group),
        .o_out_member(o_out_member)
    );

    // queue model: per-group member FIFOs plus arrival order of groups
    logic [9:0] group_members [GROUPS][$];
    logic [9:0] active_order [$];
    int         occupied;
    t_outcome   pending_outcomes [$];

    int errors;
    int idle_cycles;
    int send_gap_pct;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic t_outcome predict_queue_op(logic cmd, logic [9:0] g, logic [9:0] m);
        t_outcome r;
        r = '0;
        if (cmd == CMD_ENQ) begin
            if (occupied >= ENTRIES || int'(g) >= GROUPS) begin
                r.status = ST_FULL;
            end else begin
                if (group_members[g].size() == 0) active_order.push_back(g);
                group_members[g].push_back(m);
                occupied++;
                r.status = ST_ENQUEUED;
            end
        end else begin
            if (active_order.size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.grp = active_order[0];
                r.mem = group_members[r.grp].pop_front();
                if (group_members[r.grp].size() == 0) void'(active_order.pop_front());
                occupied--;
                r.status = ST_DEQUEUED;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                want = pending_outcomes.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_out_group !== want.grp) report_mismatch("group", o_out_group, want.grp);
                if (o_out_member !== want.mem)
                    report_mismatch("member", o_out_member, want.mem);
            end
        end
    end

    // watchdog: cycles with no transaction in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("[grouped_fifo_queue] ERROR");
                $finish;
            end
        end
    end

    task automatic send_op(logic cmd, logic [9:0] g, logic [9:0] m);
        while ($urandom_range(99) < send_gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_cmd       <= cmd;
        i_group_id  <= g;
        i_member_id <= m;
        do @(posedge i_clk); while (busy);
        pending_outcomes.push_back(predict_queue_op(cmd, g, m));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_op(CMD_DEQ, 10'd0, 10'd0);
        send_op(CMD_ENQ, 10'd0, 10'd0);
        send_op(CMD_ENQ, 10'd1023, 10'd1023);
        send_op(CMD_ENQ, 10'd0, 10'd999);
        send_op(CMD_ENQ, 10'd512, 10'd1000);
        send_op(CMD_ENQ, 10'd1023, 10'd341);
        for (int i = 0; i < 7; i++) send_op(CMD_DEQ, 10'($urandom), 10'($urandom));
        send_op(CMD_ENQ, 10'd5, 10'd682);
        send_op(CMD_DEQ, 10'd0, 10'd0);
        send_op(CMD_DEQ, 10'd0, 10'd0);
    endtask

    task automatic test_random(int n, int gap);
        int groups_span;
        send_gap_pct = gap;
        for (int i = 0; i < n; i++) begin
            groups_span = ($urandom_range(3) == 0) ? 1023 : 7;
            send_op(logic'($urandom_range(99) < 45), 10'($urandom_range(groups_span)),
                    10'($urandom));
        end
    endtask

    task automatic test_drain();
        send_gap_pct = 0;
        while (occupied > 0) send_op(CMD_DEQ, 10'($urandom), 10'($urandom));
        send_op(CMD_DEQ, 10'd0, 10'd0);
    endtask

    initial begin
        errors       = 0;
        idle_cycles  = 0;
        occupied     = 0;
        send_gap_pct = 24;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cmd        = CMD_ENQ;
        i_group_id   = '0;
        i_member_id  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(450, 24);
        wait_drained();
        test_random(450, 58);
        test_random(400, 0);
        wait_drained();
        test_drain();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("[grouped_fifo_queue] OK");
        end else begin
            $display("[grouped_fifo_queue] ERROR");
        end
        $finish;
    end
endmodule
